/* hw/rtl/pli_pkg.sv */
// Shared types and codes for the positional list block.
// Standalone package; used by pli_cell, pli_chain and the top level.
`default_nettype none

package pli_pkg;

  // Request codes on action_i
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DELETE  = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

endpackage

`default_nettype wire

/* hw/rtl/pli_cell.sv */
// One storage cell of the list chain: holds one entry and updates it from
// its neighbors. Depends on pli_pkg.
`default_nettype none

module pli_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  wire                  clk_i,
  input  wire pli_pkg::cell_op_e op_i,
  input  wire logic [IW-1:0]   sel_idx_i,
  input  wire logic [IW-1:0]   lim_idx_i,
  input  wire logic [31:0]     ins_val_i,
  input  wire logic [31:0]     head_i,
  input  wire logic [31:0]     left_i,
  input  wire logic [31:0]     right_i,
  output logic [31:0]          val_o
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [31:0] val_d;
  logic [31:0] val_q;

  // Pick next entry: shift up on insert, down on delete, wrap on rotate
  always_comb begin
    val_d = val_q;
    unique case (op_i)
      pli_pkg::CELL_HOLD: begin
        val_d = val_q;
      end
      pli_pkg::CELL_INSERT: begin
        if (MyIdx == sel_idx_i) begin
          val_d = ins_val_i;
        end else if (MyIdx > sel_idx_i) begin
          val_d = left_i;
        end
      end
      pli_pkg::CELL_DELETE: begin
        if (MyIdx >= sel_idx_i) begin
          val_d = right_i;
        end
      end
      pli_pkg::CELL_ROTATE: begin
        if (MyIdx == lim_idx_i) begin
          val_d = head_i;
        end else if (MyIdx < lim_idx_i) begin
          val_d = right_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

/* hw/rtl/pli_chain.sv */
// Row of pli_cell instances wired to their neighbors; cell 0 is the list head.
// Depends on pli_pkg and pli_cell.
`default_nettype none

module pli_chain #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned IW       = 4
) (
  input  wire                  clk_i,
  input  wire pli_pkg::cell_op_e op_i,
  input  wire logic [IW-1:0]   sel_idx_i,
  input  wire logic [IW-1:0]   lim_idx_i,
  input  wire logic [31:0]     ins_val_i,
  output logic [31:0]          head_o
);

  logic [31:0] cell_val [CAPACITY];

  // Build the chain; the ends see themselves as the missing neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_w;
    logic [31:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_val[g];
    end else begin : g_mid_l
      assign left_w = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_mid_r
      assign right_w = cell_val[g+1];
    end

    pli_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op_i),
      .sel_idx_i (sel_idx_i),
      .lim_idx_i (lim_idx_i),
      .ins_val_i (ins_val_i),
      .head_i    (cell_val[0]),
      .left_i    (left_w),
      .right_i   (right_w),
      .val_o     (cell_val[g])
    );
  end

  assign head_o = cell_val[0];

endmodule

`default_nettype wire

/* hw/rtl/positional_list_insert_delete.sv */
// Positional list top level: request decode, count and result register.
// Insert and delete: result strobed the cycle after the transfer.
// Display: busy while the list is shown (never if empty), one result per
// cycle, rate set by the chain rotating one entry into the head cell per
// cycle. Depends on pli_pkg and pli_chain.
// Reset (async, active low) empties the list; entry contents are not cleared.
`default_nettype none

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output logic               busy_o,
  input  wire logic [1:0]    action_i,
  input  wire logic [7:0]    position_i,
  input  wire logic signed [31:0] value_i,
  output logic               strobe_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               element_valid_o,
  output logic               last_o
);

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] disp_q;

  logic            accept;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic            ins_bad_pos;
  logic            del_bad_pos;
  logic            is_full;
  logic            is_empty;
  logic            disp_last;

  pli_pkg::cell_op_e cell_op;
  logic [IW-1:0]     sel_idx;
  logic [IW-1:0]     lim_idx;
  logic [31:0]       head_val;

  assign busy_o = (state_q == S_DISP);
  assign accept = start_i && !busy_o;

  // Range checks on the requested position
  assign pos_ext     = CMPW'(position_i);
  assign cnt_ext     = CMPW'(count_q);
  assign ins_bad_pos = (position_i == 8'd0) || (pos_ext > cnt_ext + CMPW'(1));
  assign del_bad_pos = (position_i == 8'd0) || (pos_ext > cnt_ext);
  assign is_full     = (count_q == CW'(CAPACITY));
  assign is_empty    = (count_q == '0);
  assign disp_last   = (disp_q + CW'(1) == count_q);

  assign sel_idx = IW'(position_i - 8'd1);
  assign lim_idx = IW'(count_q - CW'(1));

  // Drive the chain operation
  always_comb begin
    cell_op = pli_pkg::CELL_HOLD;
    if (state_q == S_DISP) begin
      cell_op = pli_pkg::CELL_ROTATE;
    end else if (accept) begin
      if (action_i == pli_pkg::ACT_INSERT && !ins_bad_pos && !is_full) begin
        cell_op = pli_pkg::CELL_INSERT;
      end else if (action_i == pli_pkg::ACT_DELETE && !is_empty && !del_bad_pos) begin
        cell_op = pli_pkg::CELL_DELETE;
      end
    end
  end

  pli_chain #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_chain (
    .clk_i     (clk_i),
    .op_i      (cell_op),
    .sel_idx_i (sel_idx),
    .lim_idx_i (lim_idx),
    .ins_val_i (value_i),
    .head_o    (head_val)
  );

  // Sequence requests, track count and register each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      count_q         <= '0;
      disp_q          <= '0;
      strobe_o        <= 1'b0;
      status_o        <= pli_pkg::ST_OK;
      element_o       <= '0;
      element_valid_o <= 1'b0;
      last_o          <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            element_o       <= '0;
            element_valid_o <= 1'b0;
            last_o          <= 1'b1;
            unique case (action_i)
              pli_pkg::ACT_INSERT: begin
                strobe_o <= 1'b1;
                if (ins_bad_pos) begin
                  status_o <= pli_pkg::ST_INVALID;
                end else if (is_full) begin
                  status_o <= pli_pkg::ST_FULL;
                end else begin
                  status_o <= pli_pkg::ST_OK;
                  count_q  <= count_q + CW'(1);
                end
              end
              pli_pkg::ACT_DELETE: begin
                strobe_o <= 1'b1;
                if (is_empty) begin
                  status_o <= pli_pkg::ST_EMPTY;
                end else if (del_bad_pos) begin
                  status_o <= pli_pkg::ST_INVALID;
                end else begin
                  status_o <= pli_pkg::ST_OK;
                  count_q  <= count_q - CW'(1);
                end
              end
              pli_pkg::ACT_DISPLAY: begin
                if (is_empty) begin
                  strobe_o <= 1'b1;
                  status_o <= pli_pkg::ST_EMPTY;
                end else begin
                  disp_q  <= '0;
                  state_q <= S_DISP;
                end
              end
              default: begin
                // drop unused action code
              end
            endcase
          end
        end
        S_DISP: begin
          strobe_o        <= 1'b1;
          status_o        <= pli_pkg::ST_OK;
          element_o       <= head_val;
          element_valid_o <= 1'b1;
          last_o          <= disp_last;
          disp_q          <= disp_q + CW'(1);
          if (disp_last) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for positional_list_insert_delete: a shadow copy of the list
// predicts every strobed result. Depends on pli_pkg and the positional list RTL.

module tb;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               valid;
    logic               last;
  } list_result_t;

  // Shadow of the list contents; holds the results still owed by the block
  class list_shadow;
    logic signed [31:0] cells [LIST_DEPTH];
    int unsigned        length;
    list_result_t       owed_q [$];
    int unsigned        mismatches;
    int unsigned        requests;
    int unsigned        results;
    int unsigned        peak_length;
    int unsigned        full_rejects;

    function new();
      length = 0;
      mismatches = 0;
      requests = 0;
      results = 0;
      peak_length = 0;
      full_rejects = 0;
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    // Apply one transferred request and queue the results it owes
    function void apply_request(logic [1:0] act, logic [7:0] pos, logic signed [31:0] val);
      list_result_t res;
      int unsigned  p;
      p = pos;
      res = '{status: pli_pkg::ST_OK, element: '0, valid: 1'b0, last: 1'b1};
      requests++;
      case (act)
        pli_pkg::ACT_INSERT: begin
          if (p < 1 || p > length + 1) begin
            res.status = pli_pkg::ST_INVALID;
          end else if (length >= LIST_DEPTH) begin
            res.status = pli_pkg::ST_FULL;
            full_rejects++;
          end else begin
            for (int i = length; i > p - 1; i--) cells[i] = cells[i-1];
            cells[p-1] = val;
            length++;
            if (length > peak_length) peak_length = length;
          end
          owed_q.push_back(res);
        end
        pli_pkg::ACT_DELETE: begin
          if (length == 0) begin
            res.status = pli_pkg::ST_EMPTY;
          end else if (p < 1 || p > length) begin
            res.status = pli_pkg::ST_INVALID;
          end else begin
            for (int i = p - 1; i + 1 < length; i++) cells[i] = cells[i+1];
            length--;
          end
          owed_q.push_back(res);
        end
        pli_pkg::ACT_DISPLAY: begin
          if (length == 0) begin
            res.status = pli_pkg::ST_EMPTY;
            owed_q.push_back(res);
          end else begin
            for (int i = 0; i < length; i++) begin
              res = '{status: pli_pkg::ST_OK, element: cells[i], valid: 1'b1,
                      last: (i + 1 == length)};
              owed_q.push_back(res);
            end
          end
        end
        default: ;  // unused code: no results
      endcase
    endfunction

    // Compare one strobed result against the oldest owed one
    task compare_result(list_result_t got);
      list_result_t want;
      results++;
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result st=%0d el=%0d v=%0b last=%0b",
                                got.status, got.element, got.valid, got.last));
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.valid !== want.valid || got.last !== want.last)
          flag_mismatch($sformatf({"got st=%0d el=%0d v=%0b last=%0b, ",
                                   "want st=%0d el=%0d v=%0b last=%0b"},
                                  got.status, got.element, got.valid, got.last,
                                  want.status, want.element, want.valid, want.last));
      end
    endtask

    task close_out();
      if (owed_q.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", owed_q.size()));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         action_i;
  logic [7:0]         position_i;
  logic signed [31:0] value_i;
  logic               strobe_o;
  logic [1:0]         status_o;
  logic signed [31:0] element_o;
  logic               element_valid_o;
  logic               last_o;

  list_shadow shadow = new();

  positional_list_insert_delete #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .strobe_o        (strobe_o),
    .status_o        (status_o),
    .element_o       (element_o),
    .element_valid_o (element_valid_o),
    .last_o          (last_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check every strobed result at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && strobe_o === 1'b1)
      shadow.compare_result('{status: status_o, element: element_o,
                              valid: element_valid_o, last: last_o});
  end

  // Present one request and hold it until the transfer
  task automatic send_request(logic [1:0] act, logic [7:0] pos, logic signed [31:0] val);
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    start_i    <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    shadow.apply_request(act, pos, val);
  endtask

  // Drop start for a caller-chosen idle stretch
  task automatic idle_cycles(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Mostly legal positions, with edges, zero, one past the end and raw bytes
  function automatic logic [7:0] pick_position(logic [1:0] act, int unsigned len);
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(99);
    top = (act == pli_pkg::ACT_INSERT) ? len + 1 : len;
    if (roll < 6) return 8'($urandom_range(255));
    if (roll < 12) return (roll < 9) ? 8'd0 : 8'(top + 1);
    if (top == 0) return 8'd1;
    if (roll < 24) return (roll < 18) ? 8'd1 : 8'(top);
    return 8'($urandom_range(top, 1));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed corners, then biased random fill, churn and drain phases
  initial begin
    int unsigned      sent;
    int unsigned      guard;
    int unsigned      ins_weight;
    int unsigned      roll;
    logic [1:0]       act;
    start_i    <= 1'b0;
    action_i   <= pli_pkg::ACT_INSERT;
    position_i <= '0;
    value_i    <= '0;
    rst_ni     <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list corners
    send_request(pli_pkg::ACT_DISPLAY, 8'd1, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd1, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd255, -32'sd1);
    send_request(pli_pkg::ACT_INSERT, 8'd0, 32'sd5);
    send_request(pli_pkg::ACT_INSERT, 8'd2, 32'sd6);
    // Insert at head, tail and middle with extreme values
    send_request(pli_pkg::ACT_INSERT, 8'd1, 32'sh7FFF_FFFF);
    send_request(pli_pkg::ACT_INSERT, 8'd2, 32'sh8000_0000);
    send_request(pli_pkg::ACT_INSERT, 8'd1, -32'sd1);
    send_request(pli_pkg::ACT_INSERT, 8'd2, 32'sd0);
    send_request(pli_pkg::ACT_INSERT, 8'd255, 32'sh5555_5555);
    send_request(ACT_UNUSED, 8'hFF, 32'shAAAA_AAAA);
    send_request(pli_pkg::ACT_DISPLAY, 8'd0, 32'sd0);
    idle_cycles(2);
    // Delete out of range, then tail, head and drain
    send_request(pli_pkg::ACT_DELETE, 8'd0, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd5, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd4, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd1, 32'sd0);
    send_request(pli_pkg::ACT_DISPLAY, 8'd7, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd1, 32'sd0);
    send_request(pli_pkg::ACT_DELETE, 8'd1, 32'sd0);
    send_request(pli_pkg::ACT_DISPLAY, 8'd0, 32'sd0);

    // Random phases alternate between filling, churning and draining
    sent = 0;
    ins_weight = 85;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0 && sent != 0)
        ins_weight = (ins_weight == 85) ? 15 : (ins_weight == 15) ? 50 : 85;
      roll = $urandom_range(99);
      if (roll < 3) act = ACT_UNUSED;
      else if (roll < 15) act = pli_pkg::ACT_DISPLAY;
      else if ($urandom_range(99) < ins_weight) act = pli_pkg::ACT_INSERT;
      else act = pli_pkg::ACT_DELETE;
      send_request(act, pick_position(act, shadow.length), pick_value());
      if (act != ACT_UNUSED) sent++;
      // Keep one long stretch free of gaps
      if ((sent < 150 || sent >= 260) && $urandom_range(99) < 7)
        idle_cycles($urandom_range(3, 1));
    end
    start_i <= 1'b0;

    // Let owed results arrive, then allow for the block's own latency
    guard = 0;
    while (shadow.owed_q.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    shadow.close_out();

    $display("Covered %0d requests and %0d strobed results; list peaked at %0d of %0d",
             shadow.requests, shadow.results, shadow.peak_length, LIST_DEPTH);
    $display("Inserts rejected on a full list: %0d", shadow.full_rejects);
    if (shadow.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pli_pkg.sv
hw/rtl/pli_cell.sv
hw/rtl/pli_chain.sv
hw/rtl/positional_list_insert_delete.sv
tb/tb.sv
